// ----- design/pid_controller_step_top_defines.svh -----
// Assertion macros for the PID controller step block.
`ifndef PID_CONTROLLER_STEP_TOP_DEFINES_SVH
`define PID_CONTROLLER_STEP_TOP_DEFINES_SVH

// Check cons in the same cycle as ante.
`define PCS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check cons in the cycle after ante.
`define PCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/pcs_pkg.sv -----
package pcs_pkg;

	localparam int DATA_W     = 16;
	localparam int DT_W       = 16;
	localparam int ERR_W      = DATA_W + 1;
	localparam int DIFF_W     = ERR_W + 1;
	localparam int PROD_W     = DATA_W + DIFF_W;
	localparam int FRAC_SHIFT = 8;
	localparam int NUM_W      = PROD_W + FRAC_SHIFT;
	localparam int DTERM_W    = NUM_W + 1;
	localparam int SUM_W      = DTERM_W + 1;
	localparam int ACC_W      = 32;
	localparam int PSUM_W     = PROD_W + 1;
	localparam int IDX_W      = 2;

	typedef enum logic [IDX_W-1:0] {
		REG_GAIN_P = 2'd0,
		REG_GAIN_I = 2'd1,
		REG_GAIN_D = 2'd2
	} cfg_reg_t;

endpackage

// ----- design/pcs_sample_if.sv -----
interface pcs_sample_if;
	import pcs_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] measured;
	logic signed [DATA_W-1:0] target;
	logic [DT_W-1:0]          step_time;

	modport source (output valid, measured, target, step_time, input ready);
	modport sink (input valid, measured, target, step_time, output ready);
endinterface

// ----- design/pcs_result_if.sv -----
interface pcs_result_if;
	import pcs_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [ACC_W-1:0] drive;
	logic                    zero_step;
	logic                    saturated;

	modport source (output valid, drive, zero_step, saturated, input ready);
	modport sink (input valid, drive, zero_step, saturated, output ready);
endinterface

// ----- design/pcs_cfg_if.sv -----
interface pcs_cfg_if;
	import pcs_pkg::*;

	logic              valid;
	logic              ready;
	logic [IDX_W-1:0]  index;
	logic [DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- design/pcs_mul.sv -----
module pcs_mul (
	input  logic                              clk,
	input  logic signed [pcs_pkg::DATA_W-1:0] a,
	input  logic signed [pcs_pkg::DIFF_W-1:0] b,
	output logic signed [pcs_pkg::PROD_W-1:0] product
);
	import pcs_pkg::*;

	logic signed [PROD_W-1:0] product_s1;

	// register the product; result is valid in the cycle after the operands
	always_ff @(posedge clk) begin
		product_s1 <= PROD_W'(a) * PROD_W'(b);
	end

	assign product = product_s1;
endmodule

// ----- design/pcs_div.sv -----
module pcs_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [pcs_pkg::NUM_W-1:0]  dividend,
	input  logic [pcs_pkg::DT_W-1:0]   divisor,
	output logic [pcs_pkg::NUM_W-1:0]  quotient,
	output logic                       done
);
	import pcs_pkg::*;

	localparam int CNT_W = $clog2(NUM_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DT_W-1:0]  rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [DT_W:0]    rem_sh;
	logic [DT_W:0]    rem_dif;
	logic             fits;

	// one restoring step: shift in the next dividend bit, subtract if it fits
	always_comb begin
		rem_sh  = {rem_q, quo_q[NUM_W-1]};
		rem_dif = rem_sh - {1'b0, divisor};
		fits    = rem_sh >= {1'b0, divisor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// dividend shifts out at the top while quotient bits shift in at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? rem_dif[DT_W-1:0] : rem_sh[DT_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;
endmodule

// ----- design/pid_controller_step_top.sv -----
// Channel  | Role   | Payload
// ---------+--------+-----------------------------------------------------
// sample   | sink   | measured (s16 Q8.8), target (s16 Q8.8), step_time (u16 Q8.8)
// result   | source | drive (s32 Q16.16), zero_step, saturated
// cfg      | sink   | index (2b: gain_p, gain_i, gain_d), data (s16 Q8.8)
//
// One item is worked through at a time: a new item is accepted only in idle,
// once the last result is loaded, and a zero step_time skips the divider.
// The 42-step restoring divider for the D term takes most of an item's time;
// P, I and the D numerator share one registered 16x18 multiplier in turn.
// Reset clears the gains, the integrator and the previous error.
// A result waits in the output register while a new item is accepted; a stalled
// result holds the sequencer only in its final step.
module pid_controller_step_top (
	input logic          clk,
	input logic          arst_n,
	pcs_sample_if.sink   sample,
	pcs_result_if.source result,
	pcs_cfg_if.sink      cfg
);
	import pcs_pkg::*;
	`include "pid_controller_step_top_defines.svh"

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL_P,
		S_MUL_I,
		S_MUL_D,
		S_DIV_LD,
		S_DIV_RUN,
		S_FIN
	} state_t;

	typedef struct packed {
		logic                    hit;
		logic signed [ACC_W-1:0] value;
	} clamp_t;

	// clamp a wide signed value to 32 bits, flag when the limit is hit
	function automatic clamp_t clamp_acc(input logic signed [SUM_W-1:0] v);
		clamp_t r;
		r.hit = !((&v[SUM_W-1:ACC_W-1]) || !(|v[SUM_W-1:ACC_W-1]));
		if (r.hit) begin
			r.value = v[SUM_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		end else begin
			r.value = v[ACC_W-1:0];
		end
		return r;
	endfunction

	state_t state_q;

	// configuration and controller state
	logic signed [DATA_W-1:0] gain_p_q;
	logic signed [DATA_W-1:0] gain_i_q;
	logic signed [DATA_W-1:0] gain_d_q;
	logic signed [ACC_W-1:0]  integ_q;
	logic signed [ERR_W-1:0]  prev_q;

	// per-item datapath registers
	logic signed [ERR_W-1:0]   err_q;
	logic signed [DIFF_W-1:0]  diff_q;
	logic [DT_W-1:0]           dt_q;
	logic signed [PROD_W-1:0]  p_q;
	logic signed [PSUM_W-1:0]  pi_q;
	logic signed [DTERM_W-1:0] d_q;
	logic                      d_neg_q;
	logic                      sat_q;
	logic                      zero_q;

	// output register
	logic                    out_valid_q;
	logic signed [ACC_W-1:0] drive_q;
	logic                    zero_step_q;
	logic                    saturated_q;

	logic                      accept;
	logic                      out_load;
	logic signed [ERR_W-1:0]   err_in;
	logic signed [DIFF_W-1:0]  diff_in;
	logic signed [DATA_W-1:0]  mul_a;
	logic signed [DIFF_W-1:0]  mul_b;
	logic signed [PROD_W-1:0]  mul_prod;
	logic [PROD_W-1:0]         prod_mag;
	logic [NUM_W-1:0]          div_num;
	logic                      div_start;
	logic [NUM_W-1:0]          div_quo;
	logic                      div_done;
	logic signed [DTERM_W-1:0] quo_ext;
	clamp_t                    int_clamp;
	clamp_t                    sum_clamp;

	assign accept   = sample.valid && (state_q == S_IDLE);
	assign out_load = (state_q == S_FIN) && (!out_valid_q || result.ready);

	// error and difference to the previous error, both exact
	always_comb begin
		err_in  = {sample.measured[DATA_W-1], sample.measured}
			- {sample.target[DATA_W-1], sample.target};
		diff_in = {prev_q[ERR_W-1], prev_q} - {err_in[ERR_W-1], err_in};
	end

	// operand select for the shared multiplier: P, then I, then D numerator
	always_comb begin
		case (state_q)
			S_MUL_P: begin
				mul_a = gain_p_q;
				mul_b = {err_q[ERR_W-1], err_q};
			end
			S_MUL_I: begin
				mul_a = gain_i_q;
				mul_b = {err_q[ERR_W-1], err_q};
			end
			default: begin
				mul_a = gain_d_q;
				mul_b = diff_q;
			end
		endcase
	end

	pcs_mul u_mul (
		.clk     (clk),
		.a       (mul_a),
		.b       (mul_b),
		.product (mul_prod)
	);

	// divide magnitudes so the quotient truncates toward zero
	always_comb begin
		prod_mag  = mul_prod[PROD_W-1] ? -mul_prod : mul_prod;
		div_num   = {prod_mag, {FRAC_SHIFT{1'b0}}};
		div_start = (state_q == S_DIV_LD) && (dt_q != '0);
		quo_ext   = {1'b0, div_quo};
		int_clamp = clamp_acc(SUM_W'(integ_q) + SUM_W'(mul_prod));
		sum_clamp = clamp_acc(SUM_W'(pi_q) + SUM_W'(d_q));
	end

	pcs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (dt_q),
		.quotient (div_quo),
		.done     (div_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			gain_p_q    <= '0;
			gain_i_q    <= '0;
			gain_d_q    <= '0;
			integ_q     <= '0;
			prev_q      <= '0;
			out_valid_q <= 1'b0;
			drive_q     <= '0;
			zero_step_q <= 1'b0;
			saturated_q <= 1'b0;
		end else begin
			// register writes; an index beyond the list is dropped
			if (cfg.valid) begin
				case (cfg_reg_t'(cfg.index))
					REG_GAIN_P: gain_p_q <= cfg.data;
					REG_GAIN_I: gain_i_q <= cfg.data;
					REG_GAIN_D: gain_d_q <= cfg.data;
					default: ;
				endcase
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						prev_q  <= err_in;
						state_q <= S_MUL_P;
					end
				end
				S_MUL_P: state_q <= S_MUL_I;
				S_MUL_I: state_q <= S_MUL_D;
				S_MUL_D: begin
					// product holds gain_i * error now
					integ_q <= int_clamp.value;
					state_q <= S_DIV_LD;
				end
				S_DIV_LD: state_q <= (dt_q == '0) ? S_FIN : S_DIV_RUN;
				S_DIV_RUN: begin
					if (div_done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			// load the output register, or drop the item once taken
			if (out_load) begin
				out_valid_q <= 1'b1;
				drive_q     <= sum_clamp.value;
				zero_step_q <= zero_q;
				saturated_q <= sat_q || sum_clamp.hit;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			err_q  <= err_in;
			diff_q <= diff_in;
			dt_q   <= sample.step_time;
		end
		if (state_q == S_MUL_I) begin
			p_q <= mul_prod;
		end
		if (state_q == S_MUL_D) begin
			sat_q <= int_clamp.hit;
		end
		if (state_q == S_DIV_LD) begin
			// integrator already holds this step's value
			pi_q    <= PSUM_W'(p_q) + PSUM_W'(integ_q);
			d_neg_q <= mul_prod[PROD_W-1];
			zero_q  <= (dt_q == '0);
			d_q     <= '0;
		end
		if ((state_q == S_DIV_RUN) && div_done) begin
			d_q <= d_neg_q ? -quo_ext : quo_ext;
		end
	end

	assign sample.ready     = (state_q == S_IDLE);
	assign cfg.ready        = 1'b1;
	assign result.valid     = out_valid_q;
	assign result.drive     = drive_q;
	assign result.zero_step = zero_step_q;
	assign result.saturated = saturated_q;

	`PCS_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, sample.valid && sample.ready,
		!sample.ready, "sequencer still ready after taking an item")
	`PCS_ASSERT_NOW(a_done_in_run, clk, arst_n, div_done, state_q == S_DIV_RUN,
		"divider finished outside the divide step")
	`PCS_ASSERT_NOW(a_start_nonzero, clk, arst_n, div_start, dt_q != '0,
		"divider started with a zero step time")
	`PCS_ASSERT_NEXT(a_fin_loads, clk, arst_n, out_load, result.valid && sample.ready,
		"final step did not load the result and return to idle")
endmodule
